FILE: src/obm_pkg.sv
// Shared types, codes and defaults of the order book matcher.
package obm_pkg;

   localparam int BOOK_DEPTH_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic CMD_LIMIT  = 1'b0;
   localparam logic CMD_MARKET = 1'b1;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_REJECTED = 2'd2;

   typedef struct packed {
      logic        cmd;
      logic        side;
      logic [15:0] order_price;
      logic [15:0] order_qty;
      logic [15:0] order_id;
   } req_type;

   typedef struct packed {
      logic        is_trade;
      logic [15:0] trade_qty;
      logic [15:0] trade_price;
      logic [15:0] first_id;
      logic [15:0] second_id;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] price;
      logic [15:0] qty;
      logic [15:0] id;
   } entry_type;

   typedef enum logic [1:0] {
      OP_LIMIT,
      OP_LIMIT_NULL,
      OP_MARKET
   } op_type;

   typedef struct packed {
      op_type    op;
      logic      side;
      entry_type entry;
   } job_type;

   typedef struct packed {
      logic        insert;
      logic        pop;
      logic        dec;
      logic [15:0] qty;
      entry_type   entry;
   } book_ctl_type;

   typedef struct packed {
      logic      empty;
      logic      full;
      entry_type top;
   } book_stat_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MARKET,
      S_MATCH,
      S_DONE
   } state_type;

endpackage

FILE: src/order_book_matcher.sv
// Top level of the limit order book matching engine.
//
// Orders enter as req_data words: push moves one in when full is low. A
// two-word queue holds classified orders for the engine. Each order yields
// zero or more trade words followed by one status word with last set; they
// leave through a two-word result queue: the head word is on rsp_data while
// empty is low, and pop takes it.
// An order is picked up in the idle state. A limit order then makes one trade
// word per step until the engine finds that the books no longer cross, and a
// status word follows; a rejected or empty one goes straight to the status
// word. A market order first fills against the other book until it is filled
// or that book ran dry, then goes on as a limit order does. The engine does
// one book update per cycle while the result queue is not full.
// Reset empties both books and both queues; no clearing pass is needed.
// If the receiver stops popping, the result queue fills and the engine
// waits; the input queue then fills and full rises.
module order_book_matcher
   import obm_pkg::*;
#(
   parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);
   job_type job;
   logic    job_valid, job_pop;
   logic    out_full, out_push;
   rsp_type out_item;

   obm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .job_pop   (job_pop),
      .job_valid (job_valid),
      .job       (job)
   );

   obm_engine #(.BOOK_DEPTH(BOOK_DEPTH)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   obm_fifo #(.DEPTH(QUEUE_DEPTH), .item_type(rsp_type)) u_out (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_item),
      .full  (out_full),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_data)
   );

   // The engine never writes a result word into a full queue.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("result written to full queue");

   // The engine only takes an order that is waiting.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid) else $error("order taken from empty queue");

   // Reset leaves the result queue empty and the input queue not full.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full)) else $error("queues not empty after reset");
endmodule

FILE: src/obm_fifo.sv
// Small first-in first-out queue of words of any packed type.
module obm_fifo
   import obm_pkg::*;
#(
   parameter int  DEPTH = QUEUE_DEPTH,
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type wdata,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type rdata
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type      mem_ff [DEPTH];
   logic [PW-1:0] wptr_ff, rptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wptr_ff <= (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         end
         if (do_pop) begin
            rptr_ff <= (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

FILE: src/obm_front.sv
// Front end: accepts orders, classifies them and queues them for the engine.
module obm_front
   import obm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    job_pop,
   output logic    job_valid,
   output job_type job
);
   job_type job_in;
   logic    job_empty;

   always_comb begin
      job_in.side        = req_data.side;
      job_in.entry.price = req_data.order_price;
      job_in.entry.qty   = req_data.order_qty;
      job_in.entry.id    = req_data.order_id;
      if (req_data.cmd == CMD_MARKET) begin
         job_in.op = OP_MARKET;
      end else if (req_data.order_qty == '0) begin
         job_in.op = OP_LIMIT_NULL;
      end else begin
         job_in.op = OP_LIMIT;
      end
   end

   obm_fifo #(.DEPTH(QUEUE_DEPTH), .item_type(job_type)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (job_in),
      .full  (full),
      .pop   (job_pop),
      .empty (job_empty),
      .rdata (job)
   );

   assign job_valid = !job_empty;
endmodule

FILE: src/obm_book.sv
// One side of the book: a sorted row of entries with insert, pop and top update.
module obm_book
   import obm_pkg::*;
#(
   parameter int DEPTH  = BOOK_DEPTH_DEF,
   parameter bit IS_BID = 1'b1
) (
   input  logic          clock,
   input  logic          reset,
   input  book_ctl_type  ctl,
   output book_stat_type stat
);
   localparam int CW = $clog2(DEPTH + 1);

   entry_type     entries_ff [DEPTH];
   entry_type     entries_in [DEPTH];
   logic [CW-1:0] count_ff;
   logic [DEPTH-1:0] ahead;

   // An entry stays ahead of a new one if its price is equal or better.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         ahead[i] = (CW'(i) < count_ff) &&
                    (IS_BID ? (entries_ff[i].price >= ctl.entry.price)
                            : (entries_ff[i].price <= ctl.entry.price));
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (ctl.insert) begin
            if (!ahead[i]) begin
               if (i == 0) begin
                  entries_in[i] = ctl.entry;
               end else if (ahead[i-1]) begin
                  entries_in[i] = ctl.entry;
               end else begin
                  entries_in[i] = entries_ff[i-1];
               end
            end
         end else if (ctl.pop) begin
            if (i < DEPTH - 1) begin
               entries_in[i] = entries_ff[i+1];
            end
         end else if (ctl.dec && i == 0) begin
            entries_in[i].qty = ctl.qty;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.insert) begin
         count_ff <= count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.top   = entries_ff[0];
endmodule

FILE: src/obm_engine.sv
// Back end: holds both books and carries out insertion, market fills and matching.
module obm_engine
   import obm_pkg::*;
#(
   parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   input  logic    out_full,
   output logic    out_push,
   output rsp_type out_item
);
   state_type     state_ff, state_in;
   logic          side_ff, side_in;
   logic [15:0]   qty_ff, qty_in;
   logic [15:0]   id_ff, id_in;
   logic [1:0]    st_ff, st_in;
   book_ctl_type  bid_ctl, ask_ctl;
   book_stat_type bid_stat, ask_stat;
   book_stat_type opp;
   logic [15:0]   q;

   obm_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b1)) u_bids (
      .clock (clock), .reset (reset), .ctl (bid_ctl), .stat (bid_stat)
   );
   obm_book #(.DEPTH(BOOK_DEPTH), .IS_BID(1'b0)) u_asks (
      .clock (clock), .reset (reset), .ctl (ask_ctl), .stat (ask_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= side_in;
      qty_ff  <= qty_in;
      id_ff   <= id_in;
      st_ff   <= st_in;
   end

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      qty_in   = qty_ff;
      id_in    = id_ff;
      st_in    = st_ff;
      job_pop  = 1'b0;
      out_push = 1'b0;
      out_item = '0;
      bid_ctl  = '0;
      ask_ctl  = '0;
      bid_ctl.entry = job.entry;
      ask_ctl.entry = job.entry;
      opp = side_ff ? ask_stat : bid_stat;
      q   = '0;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               side_in = job.side;
               qty_in  = job.entry.qty;
               id_in   = job.entry.id;
               st_in   = ST_DONE;
               case (job.op)
                  OP_LIMIT: begin
                     if (job.side ? bid_stat.full : ask_stat.full) begin
                        st_in    = ST_REJECTED;
                        state_in = S_DONE;
                     end else begin
                        bid_ctl.insert = job.side;
                        ask_ctl.insert = !job.side;
                        state_in = S_MATCH;
                     end
                  end
                  OP_MARKET: state_in = S_MARKET;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_MARKET: begin
            q = (qty_ff <= opp.top.qty) ? qty_ff : opp.top.qty;
            if (qty_ff == '0) begin
               state_in = S_MATCH;
            end else if (opp.empty) begin
               st_in    = ST_DROPPED;
               state_in = S_MATCH;
            end else if (!out_full) begin
               out_push             = 1'b1;
               out_item.is_trade    = 1'b1;
               out_item.trade_qty   = q;
               out_item.trade_price = opp.top.price;
               out_item.first_id    = id_ff;
               out_item.second_id   = opp.top.id;
               qty_in = qty_ff - q;
               if (side_ff) begin
                  ask_ctl.pop = (opp.top.qty == q);
                  ask_ctl.dec = 1'b1;
                  ask_ctl.qty = opp.top.qty - q;
               end else begin
                  bid_ctl.pop = (opp.top.qty == q);
                  bid_ctl.dec = 1'b1;
                  bid_ctl.qty = opp.top.qty - q;
               end
            end
         end
         S_MATCH: begin
            q = (ask_stat.top.qty <= bid_stat.top.qty) ? ask_stat.top.qty
                                                        : bid_stat.top.qty;
            if (!bid_stat.empty && !ask_stat.empty &&
                bid_stat.top.price >= ask_stat.top.price) begin
               if (!out_full) begin
                  out_push             = 1'b1;
                  out_item.is_trade    = 1'b1;
                  out_item.trade_qty   = q;
                  out_item.trade_price = bid_stat.top.price;
                  out_item.first_id    = ask_stat.top.id;
                  out_item.second_id   = bid_stat.top.id;
                  ask_ctl.pop = (ask_stat.top.qty == q);
                  ask_ctl.dec = 1'b1;
                  ask_ctl.qty = ask_stat.top.qty - q;
                  bid_ctl.pop = (bid_stat.top.qty == q);
                  bid_ctl.dec = 1'b1;
                  bid_ctl.qty = bid_stat.top.qty - q;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_full) begin
               out_push        = 1'b1;
               out_item.status = st_ff;
               out_item.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

FILE: tb/order_book_matcher_checker.sv
// Checker for the order book matcher: predicts trades and status words and compares them.
`timescale 1ns / 100ps
module order_book_matcher_checker
   import obm_pkg::*;
#(
   parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_words
);

   entry_type bids[$];
   entry_type asks[$];
   rsp_type   expected_words[$];

   function automatic rsp_type trade_word(logic [15:0] q, logic [15:0] p,
                                          logic [15:0] a, logic [15:0] b);
      rsp_type w;
      w = '0;
      w.is_trade = 1'b1;
      w.trade_qty = q;
      w.trade_price = p;
      w.first_id = a;
      w.second_id = b;
      return w;
   endfunction

   // Crosses the two books while the best bid reaches the best ask.
   task automatic cross_books();
      logic [15:0] q;
      while (bids.size() > 0 && asks.size() > 0 && bids[0].price >= asks[0].price) begin
         q = (asks[0].qty <= bids[0].qty) ? asks[0].qty : bids[0].qty;
         expected_words.push_back(trade_word(q, bids[0].price, asks[0].id, bids[0].id));
         asks[0].qty -= q;
         bids[0].qty -= q;
         if (asks[0].qty == 0) void'(asks.pop_front());
         if (bids[0].qty == 0) void'(bids.pop_front());
      end
   endtask

   task automatic predict_order(req_type r);
      logic [1:0]  st;
      logic [15:0] left;
      logic [15:0] q;
      entry_type   e;
      int          pos;
      rsp_type     w;
      st = ST_DONE;
      if (r.cmd == CMD_LIMIT) begin
         if (r.order_qty != 0) begin
            if ((r.side ? bids.size() : asks.size()) >= BOOK_DEPTH) begin
               st = ST_REJECTED;
            end else begin
               e.price = r.order_price;
               e.qty = r.order_qty;
               e.id = r.order_id;
               if (r.side) begin
                  pos = 0;
                  while (pos < bids.size() && bids[pos].price >= e.price) pos++;
                  bids.insert(pos, e);
               end else begin
                  pos = 0;
                  while (pos < asks.size() && asks[pos].price <= e.price) pos++;
                  asks.insert(pos, e);
               end
               cross_books();
            end
         end
      end else begin
         left = r.order_qty;
         while (left > 0) begin
            if (r.side) begin
               if (asks.size() == 0) begin
                  st = ST_DROPPED;
                  break;
               end
               q = (left <= asks[0].qty) ? left : asks[0].qty;
               expected_words.push_back(trade_word(q, asks[0].price, r.order_id, asks[0].id));
               asks[0].qty -= q;
               if (asks[0].qty == 0) void'(asks.pop_front());
            end else begin
               if (bids.size() == 0) begin
                  st = ST_DROPPED;
                  break;
               end
               q = (left <= bids[0].qty) ? left : bids[0].qty;
               expected_words.push_back(trade_word(q, bids[0].price, r.order_id, bids[0].id));
               bids[0].qty -= q;
               if (bids[0].qty == 0) void'(bids.pop_front());
            end
            left -= q;
         end
         cross_books();
      end
      w = '0;
      w.status = st;
      w.last = 1'b1;
      expected_words.push_back(w);
   endtask

   task automatic compare_word(rsp_type got);
      rsp_type want;
      if (expected_words.size() == 0) begin
         $error("unexpected result word %h", got);
         fail_count++;
         return;
      end
      want = expected_words.pop_front();
      if (got.is_trade !== want.is_trade) begin
         $error("is_trade: expected %0d, actual %0d", want.is_trade, got.is_trade);
         fail_count++;
      end
      if (got.trade_qty !== want.trade_qty) begin
         $error("trade_qty: expected %0d, actual %0d", want.trade_qty, got.trade_qty);
         fail_count++;
      end
      if (got.trade_price !== want.trade_price) begin
         $error("trade_price: expected %0d, actual %0d", want.trade_price, got.trade_price);
         fail_count++;
      end
      if (got.first_id !== want.first_id) begin
         $error("first_id: expected %0d, actual %0d", want.first_id, got.first_id);
         fail_count++;
      end
      if (got.second_id !== want.second_id) begin
         $error("second_id: expected %0d, actual %0d", want.second_id, got.second_id);
         fail_count++;
      end
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending_words = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) predict_order(req_data);
         if (pop && !empty) compare_word(rsp_data);
         pending_words = expected_words.size();
      end
   end

endmodule

FILE: tb/order_book_matcher_tb.sv
// Top of the order book matcher testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module order_book_matcher_tb;
   import obm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_words;
   int      idle_cycles;
   int      orders_sent;
   int      words_taken;
   bit      hold_off;

   order_book_matcher dut (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   order_book_matcher_checker checker_inst (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .fail_count(fail_count),
      .pending_words(pending_words)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Sends one order word and holds it until the block takes it.
   task automatic send_order(logic c, logic s, logic [15:0] p, logic [15:0] q,
                             logic [15:0] id);
      req_type r;
      r.cmd = c;
      r.side = s;
      r.order_price = p;
      r.order_qty = q;
      r.order_id = id;
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
      orders_sent++;
   endtask

   // Mostly limit orders around a narrow price band so the books cross often.
   task automatic send_random_order();
      logic        c;
      logic [15:0] p;
      logic [15:0] q;
      c = ($urandom_range(0, 9) < 2) ? CMD_MARKET : CMD_LIMIT;
      case ($urandom_range(0, 9))
         0:       p = 16'($urandom);
         1:       p = 16'hFFFF - 16'($urandom_range(0, 3));
         2:       p = 16'($urandom_range(0, 3));
         default: p = 16'd1000 + 16'($urandom_range(0, 20));
      endcase
      case ($urandom_range(0, 9))
         0:       q = 16'($urandom);
         1:       q = 16'd0;
         default: q = 16'($urandom_range(1, 40));
      endcase
      send_order(c, 1'($urandom_range(0, 1)), p, q, 16'($urandom));
   endtask

   // Receiver: stalls on its own pattern, with one long hold-off.
   always @(posedge clock) begin
      if (reset) pop <= 1'b0;
      else if (hold_off) pop <= 1'b0;
      else pop <= ((words_taken / 32) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (!reset && pop && !empty) words_taken++;
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
         $display("[order_book_matcher] ERROR");
         $finish;
      end
   end

   initial begin
      int gap;
      int burst;
      int wait_cycles;
      push = 1'b0;
      req_data = '0;
      reset = 1'b1;
      hold_off = 1'b0;
      orders_sent = 0;
      words_taken = 0;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty books, zero quantities, field extremes, full bid book.
      send_order(CMD_MARKET, 1'b1, 16'hFFFF, 16'd5, 16'd1);
      send_order(CMD_MARKET, 1'b0, 16'd0, 16'd0, 16'd2);
      send_order(CMD_LIMIT, 1'b1, 16'd500, 16'd0, 16'd3);
      for (int i = 0; i < 17; i++)
         send_order(CMD_LIMIT, 1'b1, 16'd100 + i[15:0], 16'hFFFF, 16'hFF00 + i[15:0]);
      send_order(CMD_LIMIT, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF);
      send_order(CMD_MARKET, 1'b0, 16'h1234, 16'hFFFF, 16'd0);
      send_order(CMD_LIMIT, 1'b0, 16'hFFFF, 16'd7, 16'hAAAA);
      send_order(CMD_MARKET, 1'b1, 16'd0, 16'd3, 16'h5555);
      send_order(CMD_MARKET, 1'b1, 16'd0, 16'd10, 16'h0001);

      // Random orders in bursts with gaps; long hold-off partway through.
      while (orders_sent < 370) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst; i++) send_random_order();
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (orders_sent > 150 && orders_sent < 170 && !hold_off) begin
            hold_off = 1'b1;
            fork
               begin
                  repeat (300) @(posedge clock);
                  hold_off = 1'b0;
               end
            join_none
         end
      end
      push <= 1'b0;

      wait_cycles = 0;
      while (pending_words != 0 && wait_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      $display("Sent %0d orders (limit, market, zero quantity, full book) and took %0d words.",
               orders_sent, words_taken);
      if (fail_count == 0 && pending_words == 0)
         $display("[order_book_matcher] OK");
      else
         $display("[order_book_matcher] ERROR");
      $finish;
   end

endmodule

FILE: sim.f
src/obm_pkg.sv
src/obm_fifo.sv
src/obm_front.sv
src/obm_book.sv
src/obm_engine.sv
src/order_book_matcher.sv
tb/order_book_matcher_checker.sv
tb/order_book_matcher_tb.sv
